// File: design/setq_pkg.sv
// setq_pkg: shared types and constants for the sorted expiry timer queue
// command and status structs between controller and datapath, kind codes,
// millisecond arithmetic constants; no dependencies
package setq_pkg;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_SET   = 2'd1;
  localparam logic [1:0] KIND_RESET = 2'd2;
  localparam logic [1:0] KIND_POLL  = 2'd3;

  localparam int         MS_PER_SEC  = 1000;
  // d div 1000 == (d * 67109) >> 26 for every 16-bit d
  localparam logic [16:0] RECIP_MUL  = 17'd67109;
  localparam int         RECIP_SHIFT = 26;
  localparam int         QUOT_W      = 7;

  localparam int MAX_RESULTS = 16;
  localparam int RES_CW      = $clog2(MAX_RESULTS);

  typedef struct packed {
    logic capture;    // latch input transaction, launch expiry read
    logic base_load;  // pick base time, take quotient
    logic calc_m;     // remainder plus base milliseconds
    logic calc_key;   // carry into seconds, write new expiry
    logic unlink;     // drop old queue entry of the addressed timer
    logic compare;    // compare new expiry against all slots
    logic insert;     // insert addressed timer into the queue
    logic start_wr;   // start: store current time as expiry
    logic pop;        // remove queue front
    logic load_out;   // load output register
    logic out_fired;
    logic out_last;
  } setq_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       id_ok;
    logic       due;
    logic       out_free;
  } setq_stat_t;

endpackage

// File: design/setq_ram.sv
// setq_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module setq_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/setq_datapath.sv
// setq_datapath: expiry store, sorted slot queue, delay arithmetic, output register
// depends on setq_pkg and setq_ram
module setq_datapath
  import setq_pkg::*;
#(
  parameter int NUM_TIMERS   = 16,
  parameter int SECONDS_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  setq_cmd_t   cmd,
  output setq_stat_t  stat,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_id,
  input  logic [15:0] in_delay,
  input  logic [31:0] in_now_s,
  input  logic [9:0]  in_now_m,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        out_fired,
  output logic [3:0]  out_id,
  output logic        out_hc,
  output logic        out_nv,
  output logic [31:0] out_ns,
  output logic [9:0]  out_nm,
  output logic        out_last
);

  localparam int IDW = $clog2(NUM_TIMERS);
  localparam int CW  = $clog2(NUM_TIMERS + 1);
  localparam int SB  = SECONDS_BITS;
  localparam int KW  = SB + 10;

  // captured transaction
  logic [1:0]    kind_r;
  logic [3:0]    id_r;
  logic [15:0]   d_eff_r;
  logic [SB-1:0] now_s_r;
  logic [9:0]    now_m_r;

  // arithmetic pipeline
  logic [32:0]       prod_r;
  logic [QUOT_W-1:0] q_r;
  logic [SB-1:0]     base_s_r;
  logic [9:0]        base_m_r;
  logic [10:0]       m_r;
  logic [SB-1:0]     sum_s_r;
  logic [KW-1:0]     new_key_r;
  logic              hc_r;
  logic [IDW-1:0]    pop_id_r;

  // queue
  logic [KW-1:0]         slot_key [NUM_TIMERS];
  logic [IDW-1:0]        slot_id  [NUM_TIMERS];
  logic [CW-1:0]         count;
  logic [NUM_TIMERS-1:0] active;
  logic [NUM_TIMERS-1:0] exp_valid;
  logic [NUM_TIMERS-1:0] lt_r;

  logic [SB+31:0]  now_ext;
  logic [IDW+3:0]  in_id_ext;
  logic [IDW+3:0]  id_ext;
  logic [IDW-1:0]  in_idx;
  logic [IDW-1:0]  id_idx;
  logic [15:0]     d_eff;

  logic [IDW-1:0] raddr;
  logic           ram_we;
  logic [KW-1:0]  ram_wdata;
  logic [KW-1:0]  ram_rdata;

  logic [16:0]   qk;
  logic [15:0]   rem;
  logic [1:0]    carry;
  logic [10:0]   ms_fix;
  logic [KW-1:0] key_calc;
  logic [KW-1:0] now_key;

  logic [KW-1:0]  key_up [NUM_TIMERS];
  logic [KW-1:0]  key_dn [NUM_TIMERS];
  logic [IDW-1:0] id_up  [NUM_TIMERS];
  logic [IDW-1:0] id_dn  [NUM_TIMERS];

  logic [NUM_TIMERS-1:0] rm_shift;
  logic [NUM_TIMERS-1:0] start_hit;
  logic [NUM_TIMERS-1:0] ins_at;
  logic [NUM_TIMERS-1:0] ins_dn;
  logic [NUM_TIMERS-1:0] ltm;

  logic [SB+31:0] head_s_ext;
  logic [IDW+3:0] pop_id_ext;
  logic           q_nonempty;

  assign now_ext    = {{SB{1'b0}}, in_now_s};
  assign in_id_ext  = {{IDW{1'b0}}, in_id};
  assign id_ext     = {{IDW{1'b0}}, id_r};
  assign in_idx     = in_id_ext[IDW-1:0];
  assign id_idx     = id_ext[IDW-1:0];
  assign d_eff      = (in_delay == 16'd0) ? 16'd1 : in_delay;
  assign now_key    = {now_s_r, now_m_r};
  assign q_nonempty = (count != '0);

  assign stat.kind     = kind_r;
  assign stat.id_ok    = ({3'b000, id_r} < 7'(NUM_TIMERS));
  assign stat.due      = q_nonempty && !(now_key < slot_key[0]);
  assign stat.out_free = !out_valid || out_ready;

  // expiry store, one entry per timer
  assign raddr     = cmd.capture ? in_idx : id_idx;
  assign ram_we    = cmd.start_wr || cmd.calc_key;
  assign ram_wdata = cmd.start_wr ? now_key : key_calc;

  setq_ram #(
    .WIDTH (KW),
    .DEPTH (NUM_TIMERS)
  ) u_exp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (id_idx),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // remainder and carry of milliseconds
  always_comb begin
    qk  = 17'(q_r) * 17'(MS_PER_SEC);
    rem = d_eff_r - qk[15:0];
    if (m_r >= 11'(2 * MS_PER_SEC)) begin
      carry  = 2'd2;
      ms_fix = m_r - 11'(2 * MS_PER_SEC);
    end else if (m_r >= 11'(MS_PER_SEC)) begin
      carry  = 2'd1;
      ms_fix = m_r - 11'(MS_PER_SEC);
    end else begin
      carry  = 2'd0;
      ms_fix = m_r;
    end
    key_calc = {sum_s_r + SB'(carry), ms_fix[9:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      id_r    <= in_id;
      d_eff_r <= d_eff;
      now_s_r <= now_ext[SB-1:0];
      now_m_r <= in_now_m;
      prod_r  <= 33'(d_eff) * 33'(RECIP_MUL);
    end
    if (cmd.base_load) begin
      q_r  <= prod_r[RECIP_SHIFT +: QUOT_W];
      hc_r <= 1'b0;
      if (kind_r == KIND_RESET) begin
        base_s_r <= exp_valid[id_idx] ? ram_rdata[KW-1:10] : '0;
        base_m_r <= exp_valid[id_idx] ? ram_rdata[9:0] : '0;
      end else begin
        base_s_r <= now_s_r;
        base_m_r <= now_m_r;
      end
    end
    if (cmd.calc_m) begin
      m_r     <= 11'(rem[9:0]) + 11'(base_m_r);
      sum_s_r <= base_s_r + SB'(q_r);
    end
    if (cmd.calc_key) begin
      new_key_r <= key_calc;
    end
    if (cmd.compare) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        lt_r[i] <= (CW'(i) < count) && (new_key_r < slot_key[i]);
      end
    end
    if (cmd.insert) begin
      hc_r <= ltm[0];
    end
    if (cmd.pop) begin
      pop_id_r <= slot_id[0];
    end
  end

  // neighbor views for shifting the queue
  always_comb begin
    for (int i = 0; i < NUM_TIMERS - 1; i++) begin
      key_up[i] = slot_key[i+1];
      id_up[i]  = slot_id[i+1];
    end
    key_up[NUM_TIMERS-1] = slot_key[NUM_TIMERS-1];
    id_up[NUM_TIMERS-1]  = slot_id[NUM_TIMERS-1];
    key_dn[0] = slot_key[0];
    id_dn[0]  = slot_id[0];
    for (int i = 1; i < NUM_TIMERS; i++) begin
      key_dn[i] = slot_key[i-1];
      id_dn[i]  = slot_id[i-1];
    end
  end

  // slot masks: removal point, insertion point, start hits
  always_comb begin
    logic hit_seen;
    logic ins_seen;
    hit_seen = 1'b0;
    ins_seen = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      start_hit[i] = (CW'(i) < count) && (slot_id[i] == id_idx);
      hit_seen     = hit_seen | start_hit[i];
      rm_shift[i]  = hit_seen;
      ltm[i]       = lt_r[i] | (CW'(i) == count);
      ins_dn[i]    = ins_seen;
      ins_at[i]    = ltm[i] & ~ins_seen;
      ins_seen     = ins_seen | ltm[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (cmd.unlink && active[id_idx] && rm_shift[i]) begin
        slot_key[i] <= key_up[i];
        slot_id[i]  <= id_up[i];
      end
      if (cmd.pop) begin
        slot_key[i] <= key_up[i];
        slot_id[i]  <= id_up[i];
      end
      if (cmd.insert) begin
        if (ins_dn[i]) begin
          slot_key[i] <= key_dn[i];
          slot_id[i]  <= id_dn[i];
        end else if (ins_at[i]) begin
          slot_key[i] <= new_key_r;
          slot_id[i]  <= id_idx;
        end
      end
      // start keeps the queue position, only the stored expiry moves
      if (cmd.start_wr && start_hit[i]) begin
        slot_key[i] <= now_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      active    <= '0;
      exp_valid <= '0;
    end else begin
      if (ram_we) begin
        exp_valid[id_idx] <= 1'b1;
      end
      if (cmd.unlink && active[id_idx]) begin
        count <= count - 1'b1;
      end
      if (cmd.pop) begin
        count             <= count - 1'b1;
        active[slot_id[0]] <= 1'b0;
      end
      if (cmd.insert) begin
        count          <= count + 1'b1;
        active[id_idx] <= 1'b1;
      end
    end
  end

  // output register
  assign head_s_ext = {32'd0, slot_key[0][KW-1:10]};
  assign pop_id_ext = {4'd0, pop_id_r};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_fired <= cmd.out_fired;
      out_id    <= cmd.out_fired ? pop_id_ext[3:0] : 4'd0;
      out_hc    <= cmd.out_fired ? 1'b0 : hc_r;
      out_nv    <= q_nonempty;
      out_ns    <= q_nonempty ? head_s_ext[31:0] : 32'd0;
      out_nm    <= q_nonempty ? slot_key[0][9:0] : 10'd0;
      out_last  <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: design/setq_ctrl.sv
// setq_ctrl: command sequencer for the timer queue
// depends on setq_pkg; drives setq_datapath through setq_cmd_t
module setq_ctrl
  import setq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  setq_stat_t stat,
  output setq_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_CALC1  = 4'd2;
  localparam logic [3:0] ST_CALC2  = 4'd3;
  localparam logic [3:0] ST_CMP    = 4'd4;
  localparam logic [3:0] ST_INSERT = 4'd5;
  localparam logic [3:0] ST_POLL   = 4'd6;
  localparam logic [3:0] ST_PEMIT  = 4'd7;
  localparam logic [3:0] ST_EMIT   = 4'd8;

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [RES_CW-1:0] cnt;
  logic [RES_CW-1:0] cnt_next;
  logic              more;

  assign in_ready = (state == ST_IDLE);
  // another fired result may follow only while due and under the per-poll cap
  assign more = stat.due && (cnt < RES_CW'(MAX_RESULTS - 1));

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.base_load = 1'b1;
        cnt_next      = '0;
        if (stat.kind == KIND_POLL) begin
          state_next = ST_POLL;
        end else if (!stat.id_ok) begin
          state_next = ST_EMIT;
        end else if (stat.kind == KIND_START) begin
          cmd.start_wr = 1'b1;
          state_next   = ST_EMIT;
        end else begin
          state_next = ST_CALC1;
        end
      end
      ST_CALC1: begin
        cmd.calc_m = 1'b1;
        state_next = ST_CALC2;
      end
      ST_CALC2: begin
        cmd.calc_key = 1'b1;
        cmd.unlink   = 1'b1;
        state_next   = ST_CMP;
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_next  = ST_INSERT;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = ST_EMIT;
      end
      ST_POLL: begin
        if (stat.due) begin
          cmd.pop    = 1'b1;
          state_next = ST_PEMIT;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_PEMIT: begin
        if (stat.out_free) begin
          cmd.load_out  = 1'b1;
          cmd.out_fired = 1'b1;
          cmd.out_last  = !more;
          cnt_next      = cnt + 1'b1;
          state_next    = more ? ST_POLL : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// File: design/sorted_expiry_timer_queue_core.sv
// sorted_expiry_timer_queue_core: top level of the sorted one-shot timer queue
// depends on setq_pkg, setq_ctrl, setq_datapath (which holds setq_ram)
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tuser kind, s_tdata timer command and time
//   m_*      out  m_tvalid/m_tready  m_tuser fired_valid, m_tdata result, m_tlast
//
// one command is worked at a time; input is taken only when the sequencer idles
// start and ignored commands: accept, decode, then emit into the result register
// set and reset: decode, expiry arithmetic (calc1, calc2), slot compare, insert, then emit
// poll: decode, then a pop and a result load per due timer; if nothing is due, one empty result
// reset clears queue count, active marks and expiry valid bits
// a stalled result holds the sequencer; nothing is dropped
module sorted_expiry_timer_queue_core
  import setq_pkg::*;
#(
  parameter int NUM_TIMERS   = 16,
  parameter int SECONDS_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [3:0] timer_id, [19:4] delay_ms, [51:20] now_seconds, [61:52] now_millis
  input  logic [63:0] s_tdata,
  // [1:0] kind
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] fired_id, [4] head_changed, [5] next_valid, [37:6] next_seconds,
  // [47:38] next_millis
  output logic [47:0] m_tdata,
  // [0] fired_valid
  output logic        m_tuser,
  output logic        m_tlast
);

  setq_cmd_t  cmd;
  setq_stat_t stat;

  logic        out_fired;
  logic [3:0]  out_id;
  logic        out_hc;
  logic        out_nv;
  logic [31:0] out_ns;
  logic [9:0]  out_nm;

  setq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  setq_datapath #(
    .NUM_TIMERS   (NUM_TIMERS),
    .SECONDS_BITS (SECONDS_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_kind   (s_tuser),
    .in_id     (s_tdata[3:0]),
    .in_delay  (s_tdata[19:4]),
    .in_now_s  (s_tdata[51:20]),
    .in_now_m  (s_tdata[61:52]),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_fired (out_fired),
    .out_id    (out_id),
    .out_hc    (out_hc),
    .out_nv    (out_nv),
    .out_ns    (out_ns),
    .out_nm    (out_nm),
    .out_last  (m_tlast)
  );

  assign m_tdata = {out_nm, out_ns, out_nv, out_hc, out_id};
  assign m_tuser = out_fired;

  // result register is never overwritten while a transaction is pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result overwritten while pending");

  // only one command in flight
  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while busy");

  // queue-changing commands never overlap
  a_queue_ops: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.insert, cmd.pop, cmd.unlink, cmd.start_wr}))
    else $error("overlapping queue operations");

  // a result without a fired timer always closes its command
  a_quiet_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && !cmd.out_fired) |=> (m_tvalid && m_tlast && !m_tuser))
    else $error("non-fired result not marked last");

endmodule
